@@ hw/rtl/tfm_pkg.sv @@
// ----------------------------------------------------------------------------
// Timestamp frequency meter package
// Widths, register indexes and the sequencer state type shared by the meter.
// ----------------------------------------------------------------------------
package tfm_pkg;

    // Width of the running tick counter.
    localparam int COUNT_BITS = 32;

    // Field and register widths.
    localparam int STAMP_W    = 64;
    localparam int INTERVAL_W = 16;
    localparam int RATE_W     = 24;
    localparam int LATCH_W    = 16;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Shared multiplier: one operand is a timestamp half or the tick count,
    // the other is the tick rate or the latch value.
    localparam int HALF_W  = STAMP_W / 2;
    localparam int MUL_A_W = (COUNT_BITS > HALF_W) ? COUNT_BITS : HALF_W;
    localparam int PROD_W  = MUL_A_W + RATE_W;

    // Numerator, divisor and divider step counter widths.
    localparam int NUM_W   = STAMP_W + RATE_W;
    localparam int DIV_W   = COUNT_BITS + LATCH_W;
    localparam int STEP_W  = $clog2(NUM_W);

    // Count extended to at least the output width for saturation.
    localparam int CNT_EXT_W = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // Register reset values.
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(500);
    localparam logic [RATE_W-1:0]     RATE_RST     = RATE_W'(1193180);
    localparam logic [LATCH_W-1:0]    LATCH_RST    = LATCH_W'(11932);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH    = 2'd2;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SUB   = 9'b000000010,
        ST_MUL0  = 9'b000000100,
        ST_MUL1  = 9'b000001000,
        ST_MUL2  = 9'b000010000,
        ST_MUL3  = 9'b000100000,
        ST_DIV   = 9'b001000000,
        ST_ROUND = 9'b010000000,
        ST_OUT   = 9'b100000000
    } t_state;

endpackage

@@ hw/rtl/timestamp_frequency_meter.sv @@
// ----------------------------------------------------------------------------
// Timestamp frequency meter
// Measures a free-running counter's clock against a periodic reference tick.
// ----------------------------------------------------------------------------
// Each input request is one reference tick carrying a 64-bit timestamp. The
// first tick captures the base timestamp; later ticks advance a saturating
// running count. A 16-bit window counter advances on every tick, and when it
// equals report_interval the block emits one result request:
//   measured_hz = round((ts - base) * tick_rate / (count * latch)),
// ties rounded down, saturated at 2^32-1, together with the running count.
// A tick that does not close a window leaves the sequencer idle, so o_stall
// stays low. A reporting tick steps through the subtraction, the states around
// a shared 32x24 multiplier, a one-bit-per-cycle restoring divider over the
// 88-bit numerator and a rounding state, after which o_valid rises. o_stall
// stays high from the tick until the result is taken, so a stalled receiver
// holds off new ticks and the result holds steady. Reset clears the base,
// count, window counter and sequencer and loads the default register values.
// Configuration writes are always accepted and should be issued while the
// block is idle.
// ----------------------------------------------------------------------------
module timestamp_frequency_meter
    import tfm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Tick channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [STAMP_W-1:0]    i_timestamp,
    // Result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [OUT_W-1:0]      o_measured_hz,
    output logic [OUT_W-1:0]      o_ticks_counted,
    // Configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state                 r_state, n_state;

    logic [INTERVAL_W-1:0]  r_interval;
    logic [RATE_W-1:0]      r_rate;
    logic [LATCH_W-1:0]     r_latch;

    logic [STAMP_W-1:0]     r_base;
    logic                   r_started;
    logic [COUNT_BITS-1:0]  r_total;
    logic [INTERVAL_W-1:0]  r_window;
    logic [INTERVAL_W-1:0]  n_window;

    logic [STAMP_W-1:0]     r_stamp;
    logic [PROD_W-1:0]      r_prod;
    logic [NUM_W-1:0]       r_num;
    logic [DIV_W-1:0]       r_div;
    logic [DIV_W-1:0]       r_rem;
    logic [OUT_W-1:0]       r_quo;
    logic                   r_ovf;
    logic [STEP_W-1:0]      r_step;

    logic [OUT_W-1:0]       r_hz;
    logic [OUT_W-1:0]       r_ticks;

    logic                   in_take;
    logic [MUL_A_W-1:0]     mul_a;
    logic [RATE_W-1:0]      mul_b;
    logic [PROD_W-1:0]      mul_p;
    logic [DIV_W:0]         shifted;
    logic                   ge;
    logic [DIV_W:0]         diff;
    logic                   sat;
    logic                   rnd;
    logic [CNT_EXT_W-1:0]   total_ext;

    // Handshakes.
    assign in_take     = i_valid && (r_state == ST_IDLE);
    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = (r_state == ST_OUT);
    assign o_cfg_ready = 1'b1;
    assign n_window    = r_window + 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RST;
            r_rate     <= RATE_RST;
            r_latch    <= LATCH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INTERVAL: r_interval <= i_cfg_data[INTERVAL_W-1:0];
                REG_RATE:     r_rate     <= i_cfg_data[RATE_W-1:0];
                REG_LATCH:    r_latch    <= i_cfg_data[LATCH_W-1:0];
                default:      ;
            endcase
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = MUL_A_W'(r_total);
        mul_b = RATE_W'(r_latch);
        case (r_state)
            ST_MUL0: begin
                mul_a = MUL_A_W'(r_stamp[HALF_W-1:0]);
                mul_b = r_rate;
            end
            ST_MUL1: begin
                mul_a = MUL_A_W'(r_stamp[STAMP_W-1:HALF_W]);
                mul_b = r_rate;
            end
            default: ;
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // One restoring divider step.
    assign shifted = {r_rem, r_num[NUM_W-1]};
    assign ge      = (shifted >= {1'b0, r_div});
    assign diff    = shifted - {1'b0, r_div};

    // Rounding and saturation of the final quotient.
    assign sat = (r_div == '0) || r_ovf || (r_quo == OUT_MAX);
    assign rnd = ({r_rem, 1'b0} > {1'b0, r_div});

    assign total_ext = CNT_EXT_W'(r_total);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take && (n_window == r_interval)) begin
                    n_state = ST_SUB;
                end
            end
            ST_SUB:   n_state = ST_MUL0;
            ST_MUL0:  n_state = ST_MUL1;
            ST_MUL1:  n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_MUL3;
            ST_MUL3:  n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: n_state = ST_OUT;
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control state: sequencer, base capture, running count, window counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_base    <= '0;
            r_started <= 1'b0;
            r_total   <= '0;
            r_window  <= '0;
        end else begin
            r_state <= n_state;
            if (in_take) begin
                if (!r_started) begin
                    r_base    <= i_timestamp;
                    r_started <= 1'b1;
                end else if (r_total != '1) begin
                    r_total <= r_total + 1'b1;
                end
                // The window restarts on a reporting tick.
                r_window <= (n_window == r_interval) ? '0 : n_window;
            end
        end
    end

    // Datapath: difference, products, divider and result registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_stamp <= i_timestamp;
            end
            ST_SUB: begin
                r_stamp <= r_stamp - r_base;
            end
            ST_MUL0: begin
                r_prod <= mul_p;
            end
            ST_MUL1: begin
                r_num  <= NUM_W'(r_prod);
                r_prod <= mul_p;
            end
            ST_MUL2: begin
                r_num  <= r_num + (NUM_W'(r_prod) << HALF_W);
                r_prod <= mul_p;
            end
            ST_MUL3: begin
                r_div  <= r_prod[DIV_W-1:0];
                r_rem  <= '0;
                r_quo  <= '0;
                r_ovf  <= 1'b0;
                r_step <= '0;
            end
            ST_DIV: begin
                r_rem  <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
                r_quo  <= {r_quo[OUT_W-2:0], ge};
                r_ovf  <= r_ovf | r_quo[OUT_W-1];
                r_num  <= r_num << 1;
                r_step <= r_step + 1'b1;
            end
            ST_ROUND: begin
                r_hz    <= sat ? OUT_MAX : (r_quo + OUT_W'(rnd));
                r_ticks <= (total_ext > CNT_EXT_W'(OUT_MAX)) ? OUT_MAX
                                                             : total_ext[OUT_W-1:0];
            end
            default: ;
        endcase
    end

    assign o_measured_hz   = r_hz;
    assign o_ticks_counted = r_ticks;

endmodule
